// ===== sv/oac_pkg.sv =====
// ----------------------------------------------------------------------------
// oac_pkg
// Shared types and constants for the occupancy alarm controller.
// ----------------------------------------------------------------------------
package oac_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_WARNING  = 2'd1,
    MODE_OCCUPIED = 2'd2
  } mode_t;

  localparam logic [1:0] ALARM_FIRE = 2'd3;

  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_GREEN  = 2'd1;
  localparam logic [1:0] LED_YELLOW = 2'd2;
  localparam logic [1:0] LED_RED    = 2'd3;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WARNING_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_FRAMES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUZZER_HALF   = 3'd4;

  localparam logic [15:0] WARNING_DELAY_RST = 16'd3000;
  localparam logic [15:0] ALARM_DELAY_RST   = 16'd5000;
  localparam logic [7:0]  DETECT_FRAMES_RST = 8'd3;
  localparam logic [7:0]  CLEAR_FRAMES_RST  = 8'd3;
  localparam logic [15:0] BUZZER_HALF_RST   = 16'd500;

  localparam int QDEPTH = 3;

  typedef struct packed {
    logic [15:0] warning_delay_ticks;
    logic [15:0] alarm_delay_ticks;
    logic [7:0]  detect_frames;
    logic [7:0]  clear_frames;
    logic [15:0] buzzer_half_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  alarm_state;
    logic [1:0]  led_color;
    logic        buzzer_on;
    logic        presence;
    logic [16:0] ticks_to_alarm;
  } result_t;

endpackage

// ===== sv/oac_cfg.sv =====
// ----------------------------------------------------------------------------
// oac_cfg
// Configuration register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module oac_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oac_pkg::CFG_DATA_W-1:0] cfg_data,
  output oac_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warning_delay_ticks <= oac_pkg::WARNING_DELAY_RST;
      cfg.alarm_delay_ticks   <= oac_pkg::ALARM_DELAY_RST;
      cfg.detect_frames       <= oac_pkg::DETECT_FRAMES_RST;
      cfg.clear_frames        <= oac_pkg::CLEAR_FRAMES_RST;
      cfg.buzzer_half_period  <= oac_pkg::BUZZER_HALF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        oac_pkg::REG_WARNING_DELAY: cfg.warning_delay_ticks <= cfg_data;
        oac_pkg::REG_ALARM_DELAY:   cfg.alarm_delay_ticks   <= cfg_data;
        oac_pkg::REG_DETECT_FRAMES: cfg.detect_frames       <= cfg_data[7:0];
        oac_pkg::REG_CLEAR_FRAMES:  cfg.clear_frames        <= cfg_data[7:0];
        oac_pkg::REG_BUZZER_HALF:   cfg.buzzer_half_period  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/oac_core.sv =====
// ----------------------------------------------------------------------------
// oac_core
// Input register, debounce counters, stability timer and alarm state machine.
// Produces one result word per item, in the cycle after it is taken.
// ----------------------------------------------------------------------------
module oac_core (
  input  logic             clk,
  input  logic             rst,
  input  oac_pkg::cfg_t    cfg,
  input  logic             take,
  input  logic             kind,
  input  logic             target_seen,
  input  logic             flame_seen,
  output logic             pend,
  output oac_pkg::result_t result
);

  localparam logic [16:0] STABLE_MAX = '1;
  localparam logic [15:0] TOGGLE_MAX = '1;
  localparam logic [7:0]  COUNT_MAX  = '1;

  logic kind_q, target_q, flame_q;

  logic [7:0]     hit_count, hit_count_next;
  logic [7:0]     miss_count, miss_count_next;
  logic           present_flag, present_flag_next;
  logic           timer_running, timer_running_next;
  logic [16:0]    stable_ticks, stable_ticks_next;
  oac_pkg::mode_t mode, mode_next;
  logic           fire_latched, fire_latched_next;
  logic           buzzer_phase, buzzer_phase_next;
  logic [15:0]    since_toggle, since_toggle_next;
  logic [1:0]     led_reg, led_reg_next;
  logic           buzzer_reg, buzzer_reg_next;

  logic [16:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_q   <= kind;
      target_q <= target_seen;
      flame_q  <= flame_seen;
    end
  end

  assign limit = {1'b0, cfg.warning_delay_ticks} + {1'b0, cfg.alarm_delay_ticks};

  // item update and state machine
  always_comb begin
    logic do_eval;
    hit_count_next     = hit_count;
    miss_count_next    = miss_count;
    present_flag_next  = present_flag;
    timer_running_next = timer_running;
    stable_ticks_next  = stable_ticks;
    mode_next          = mode;
    fire_latched_next  = fire_latched;
    buzzer_phase_next  = buzzer_phase;
    since_toggle_next  = since_toggle;
    led_reg_next       = led_reg;
    buzzer_reg_next    = buzzer_reg;
    do_eval            = 1'b0;

    if (kind_q == oac_pkg::KIND_TICK) begin
      if (since_toggle != TOGGLE_MAX) begin
        since_toggle_next = since_toggle + 16'd1;
      end
      if (timer_running && stable_ticks != STABLE_MAX) begin
        stable_ticks_next = stable_ticks + 17'd1;
      end
      do_eval = !fire_latched;
    end else if (flame_q) begin
      fire_latched_next = 1'b1;
      led_reg_next      = oac_pkg::LED_RED;
      buzzer_reg_next   = 1'b1;
    end else begin
      if (fire_latched) begin
        fire_latched_next  = 1'b0;
        mode_next          = oac_pkg::MODE_IDLE;
        led_reg_next       = oac_pkg::LED_GREEN;
        buzzer_reg_next    = 1'b0;
        present_flag_next  = 1'b0;
        timer_running_next = 1'b0;
      end
      if (target_q) begin
        if (hit_count != COUNT_MAX) begin
          hit_count_next = hit_count + 8'd1;
        end
        miss_count_next = '0;
      end else begin
        if (miss_count != COUNT_MAX) begin
          miss_count_next = miss_count + 8'd1;
        end
        hit_count_next = '0;
      end
      if (hit_count_next >= cfg.detect_frames && !present_flag_next) begin
        present_flag_next  = 1'b1;
        stable_ticks_next  = '0;
        timer_running_next = 1'b1;
      end else if (miss_count_next >= cfg.clear_frames && present_flag_next) begin
        present_flag_next  = 1'b0;
        timer_running_next = 1'b0;
        mode_next          = oac_pkg::MODE_IDLE;
        led_reg_next       = oac_pkg::LED_GREEN;
        buzzer_reg_next    = 1'b0;
      end
      do_eval = 1'b1;
    end

    if (do_eval) begin
      if (!present_flag_next || !timer_running_next) begin
        if (mode_next != oac_pkg::MODE_IDLE) begin
          mode_next       = oac_pkg::MODE_IDLE;
          led_reg_next    = oac_pkg::LED_GREEN;
          buzzer_reg_next = 1'b0;
        end
      end else begin
        case (mode_next)
          oac_pkg::MODE_IDLE: begin
            if (stable_ticks_next >= {1'b0, cfg.warning_delay_ticks}) begin
              mode_next    = oac_pkg::MODE_WARNING;
              led_reg_next = oac_pkg::LED_YELLOW;
            end
          end
          oac_pkg::MODE_WARNING: begin
            // stable >= warning + alarm covers both tests
            if (stable_ticks_next >= limit) begin
              mode_next    = oac_pkg::MODE_OCCUPIED;
              led_reg_next = oac_pkg::LED_RED;
            end else begin
              led_reg_next = oac_pkg::LED_YELLOW;
            end
          end
          default: begin
            led_reg_next = oac_pkg::LED_RED;
            if (since_toggle_next >= cfg.buzzer_half_period) begin
              buzzer_phase_next = !buzzer_phase;
              buzzer_reg_next   = !buzzer_phase;
              since_toggle_next = '0;
            end
          end
        endcase
      end
    end
  end

  // result word from the updated state
  always_comb begin
    result.alarm_state    = fire_latched_next ? oac_pkg::ALARM_FIRE : 2'(mode_next);
    result.led_color      = led_reg_next;
    result.buzzer_on      = buzzer_reg_next;
    result.presence       = present_flag_next;
    result.ticks_to_alarm = '0;
    if (!fire_latched_next && mode_next == oac_pkg::MODE_WARNING && timer_running_next &&
        stable_ticks_next < limit) begin
      result.ticks_to_alarm = limit - stable_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count     <= '0;
      miss_count    <= '0;
      present_flag  <= 1'b0;
      timer_running <= 1'b0;
      stable_ticks  <= '0;
      mode          <= oac_pkg::MODE_IDLE;
      fire_latched  <= 1'b0;
      buzzer_phase  <= 1'b0;
      since_toggle  <= '0;
      led_reg       <= oac_pkg::LED_OFF;
      buzzer_reg    <= 1'b0;
    end else if (pend) begin
      hit_count     <= hit_count_next;
      miss_count    <= miss_count_next;
      present_flag  <= present_flag_next;
      timer_running <= timer_running_next;
      stable_ticks  <= stable_ticks_next;
      mode          <= mode_next;
      fire_latched  <= fire_latched_next;
      buzzer_phase  <= buzzer_phase_next;
      since_toggle  <= since_toggle_next;
      led_reg       <= led_reg_next;
      buzzer_reg    <= buzzer_reg_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_fire_drive: assert property (@(posedge clk) disable iff (rst)
    fire_latched |-> (led_reg == oac_pkg::LED_RED && buzzer_reg))
    else $error("fire latched without red LED and buzzer");

  a_timer_presence: assert property (@(posedge clk) disable iff (rst)
    present_flag == timer_running)
    else $error("stability timer out of step with presence");

  a_mode_needs_presence: assert property (@(posedge clk) disable iff (rst)
    (mode != oac_pkg::MODE_IDLE) |-> present_flag)
    else $error("non-idle mode without presence");

  a_quiet_hold: assert property (@(posedge clk) disable iff (rst)
    !pend |=> ($stable(mode) && $stable(stable_ticks) && $stable(fire_latched)))
    else $error("state changed with no item in flight");
`endif

endmodule

// ===== sv/oac_out_fifo.sv =====
// ----------------------------------------------------------------------------
// oac_out_fifo
// Three-word result queue; decouples the core from output stalls.
// ----------------------------------------------------------------------------
module oac_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  oac_pkg::result_t wdata,
  input  logic             out_stall,
  output logic             out_valid,
  output oac_pkg::result_t rdata,
  output logic [1:0]       count
);

  localparam logic [1:0] LAST = 2'(oac_pkg::QDEPTH - 1);

  oac_pkg::result_t mem [oac_pkg::QDEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? 2'd0 : rd_ptr + 2'd1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == 2'(oac_pkg::QDEPTH)))
    else $error("result queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(oac_pkg::QDEPTH))
    else $error("result queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");
`endif

endmodule

// ===== sv/occupancy_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// occupancy_alarm_controller_unit
// Debounced presence and flame alarm controller with LED and buzzer drive.
// ----------------------------------------------------------------------------
// Each accepted word (a one millisecond tick or a frame result) yields exactly
// one result word. A word is registered on entry, the whole state update runs
// in the next cycle and its result lands in a three-word output queue; one word
// can be taken every cycle while in_stall is low. in_stall rises only when the
// output queue, counting the word in flight, is full. Config writes are always
// ready and should be issued while no word is in flight.
module occupancy_alarm_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic                           target_seen,
  input  logic                           flame_seen,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     alarm_state,
  output logic [1:0]                     led_color,
  output logic                           buzzer_on,
  output logic                           presence,
  output logic [16:0]                    ticks_to_alarm,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [oac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oac_pkg::CFG_DATA_W-1:0] cfg_data
);

  oac_pkg::cfg_t    cfg;
  oac_pkg::result_t core_res, out_res;
  logic             take, pend;
  logic [1:0]       count;

  assign in_stall = (count == 2'(oac_pkg::QDEPTH)) ||
                    (count == 2'(oac_pkg::QDEPTH - 1) && pend);
  assign take     = in_valid && !in_stall;

  oac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oac_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .kind        (kind),
    .target_seen (target_seen),
    .flame_seen  (flame_seen),
    .pend        (pend),
    .result      (core_res)
  );

  oac_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (pend),
    .wdata     (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .rdata     (out_res),
    .count     (count)
  );

  assign alarm_state    = out_res.alarm_state;
  assign led_color      = out_res.led_color;
  assign buzzer_on      = out_res.buzzer_on;
  assign presence       = out_res.presence;
  assign ticks_to_alarm = out_res.ticks_to_alarm;

endmodule

// ===== verif/oac_alarm_checker.sv =====
// ----------------------------------------------------------------------------
// oac_alarm_checker
// Watches the word, result and config channels of the occupancy alarm
// controller. It keeps its own copy of the debounce, timer, buzzer and fire
// state, predicts the result of every accepted word and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module oac_alarm_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           kind,
  input  logic                           target_seen,
  input  logic                           flame_seen,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [1:0]                     alarm_state,
  input  logic [1:0]                     led_color,
  input  logic                           buzzer_on,
  input  logic                           presence,
  input  logic [16:0]                    ticks_to_alarm,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [oac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [oac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    pending,
  output int unsigned                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] STABLE_MAX = 17'h1FFFF;
  localparam logic [15:0] SINCE_MAX  = 16'hFFFF;

  oac_pkg::cfg_t    cfg;
  logic [7:0]       hits;
  logic [7:0]       misses;
  logic             present;
  logic             timing;
  logic [16:0]      stable;
  oac_pkg::mode_t   mode;
  logic             fire;
  logic             phase_bit;
  logic [15:0]      since_tog;
  logic [1:0]       led;
  logic             buzz;

  oac_pkg::result_t alarm_q[$];
  oac_pkg::result_t want;
  oac_pkg::result_t fresh;
  int unsigned      mism = 0;

  function automatic void enter_idle();
    mode = oac_pkg::MODE_IDLE;
    led  = oac_pkg::LED_GREEN;
    buzz = 1'b0;
  endfunction

  function automatic void step_fsm();
    if (!present || !timing) begin
      if (mode != oac_pkg::MODE_IDLE) enter_idle();
    end else begin
      case (mode)
        oac_pkg::MODE_IDLE: begin
          if (stable >= 17'(cfg.warning_delay_ticks)) begin
            mode = oac_pkg::MODE_WARNING;
            led  = oac_pkg::LED_YELLOW;
          end
        end
        oac_pkg::MODE_WARNING: begin
          if (stable >= 17'(cfg.warning_delay_ticks) &&
              (stable - 17'(cfg.warning_delay_ticks)) >= 17'(cfg.alarm_delay_ticks)) begin
            mode = oac_pkg::MODE_OCCUPIED;
            led  = oac_pkg::LED_RED;
          end else begin
            led = oac_pkg::LED_YELLOW;
          end
        end
        default: begin
          led = oac_pkg::LED_RED;
          if (since_tog >= cfg.buzzer_half_period) begin
            phase_bit = ~phase_bit;
            buzz      = phase_bit;
            since_tog = '0;
          end
        end
      endcase
    end
  endfunction

  function automatic oac_pkg::result_t predict_alarm(input logic k, input logic t,
                                                     input logic f);
    oac_pkg::result_t r;
    logic [16:0]      limit;
    r = '0;
    if (k == oac_pkg::KIND_TICK) begin
      if (since_tog != SINCE_MAX) since_tog = since_tog + 16'd1;
      if (timing && stable != STABLE_MAX) stable = stable + 17'd1;
      if (!fire) step_fsm();
    end else if (f) begin
      fire = 1'b1;
      led  = oac_pkg::LED_RED;
      buzz = 1'b1;
    end else begin
      if (fire) begin
        fire = 1'b0;
        enter_idle();
        present = 1'b0;
        timing  = 1'b0;
      end
      if (t) begin
        if (hits != 8'hFF) hits = hits + 8'd1;
        misses = '0;
      end else begin
        if (misses != 8'hFF) misses = misses + 8'd1;
        hits = '0;
      end
      if (hits >= cfg.detect_frames && !present) begin
        present = 1'b1;
        stable  = '0;
        timing  = 1'b1;
      end else if (misses >= cfg.clear_frames && present) begin
        present = 1'b0;
        timing  = 1'b0;
        enter_idle();
      end
      step_fsm();
    end
    r.alarm_state = fire ? oac_pkg::ALARM_FIRE : 2'(mode);
    r.led_color   = led;
    r.buzzer_on   = buzz;
    r.presence    = present;
    if (!fire && mode == oac_pkg::MODE_WARNING && timing) begin
      limit = 17'(cfg.warning_delay_ticks) + 17'(cfg.alarm_delay_ticks);
      r.ticks_to_alarm = (stable < limit) ? limit - stable : '0;
    end
    return r;
  endfunction

  function automatic void check_field(input string nm, input logic [16:0] exp_v,
                                      input logic [16:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, nm, exp_v, got_v);
      mism++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.warning_delay_ticks = oac_pkg::WARNING_DELAY_RST;
      cfg.alarm_delay_ticks   = oac_pkg::ALARM_DELAY_RST;
      cfg.detect_frames       = oac_pkg::DETECT_FRAMES_RST;
      cfg.clear_frames        = oac_pkg::CLEAR_FRAMES_RST;
      cfg.buzzer_half_period  = oac_pkg::BUZZER_HALF_RST;
      hits      = '0;
      misses    = '0;
      present   = 1'b0;
      timing    = 1'b0;
      stable    = '0;
      mode      = oac_pkg::MODE_IDLE;
      fire      = 1'b0;
      phase_bit = 1'b0;
      since_tog = '0;
      led       = oac_pkg::LED_OFF;
      buzz      = 1'b0;
      alarm_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (alarm_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual state %0d led %0d",
                   $time, alarm_state, led_color);
          mism++;
        end else begin
          want = alarm_q.pop_front();
          check_field("alarm_state", 17'(want.alarm_state), 17'(alarm_state));
          check_field("led_color", 17'(want.led_color), 17'(led_color));
          check_field("buzzer_on", 17'(want.buzzer_on), 17'(buzzer_on));
          check_field("presence", 17'(want.presence), 17'(presence));
          check_field("ticks_to_alarm", want.ticks_to_alarm, ticks_to_alarm);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          oac_pkg::REG_WARNING_DELAY: cfg.warning_delay_ticks = cfg_data;
          oac_pkg::REG_ALARM_DELAY:   cfg.alarm_delay_ticks   = cfg_data;
          oac_pkg::REG_DETECT_FRAMES: cfg.detect_frames       = cfg_data[7:0];
          oac_pkg::REG_CLEAR_FRAMES:  cfg.clear_frames        = cfg_data[7:0];
          oac_pkg::REG_BUZZER_HALF:   cfg.buzzer_half_period  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fresh   = predict_alarm(kind, target_seen, flame_seen);
        alarm_q = {alarm_q, fresh};
      end
    end
    pending    <= alarm_q.size();
    fail_count <= mism;
  end

endmodule

// ===== verif/tb_occupancy_alarm_controller_unit.sv =====
// ----------------------------------------------------------------------------
// tb_occupancy_alarm_controller_unit
// Drives tick and frame words into the occupancy alarm controller in random
// bursts while the result side stalls on its own pattern. A short directed
// run covers fire, zero thresholds and buzzer toggling, a deep run reaches
// counter saturation and a raised warning delay, then random phases with
// mixed register settings follow. The checker reports the verdict input.
// ----------------------------------------------------------------------------
module tb_occupancy_alarm_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [oac_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned                   LIMIT     = 2_000_000;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic                           kind        = oac_pkg::KIND_TICK;
  logic                           target_seen = 1'b0;
  logic                           flame_seen  = 1'b0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [1:0]                     alarm_state;
  logic [1:0]                     led_color;
  logic                           buzzer_on;
  logic                           presence;
  logic [16:0]                    ticks_to_alarm;
  logic                           cfg_valid   = 1'b0;
  logic                           cfg_ready;
  logic [oac_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [oac_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  int unsigned                    pending;
  int unsigned                    fail_count;

  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  bit          quiet       = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned stall_style = 0;

  occupancy_alarm_controller_unit u_dut (.*);

  oac_alarm_checker u_checker (.*);

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("occupancy_alarm_controller_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: out_stall <= (stall_left[3:0] < 4'd6);
    endcase
  end

  task automatic send_word(input logic k, input logic t, input logic f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    kind        <= k;
    target_seen <= t;
    flame_seen  <= f;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [oac_pkg::CFG_IDX_W-1:0] idx,
                         input logic [oac_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input oac_pkg::cfg_t c, input bit spare);
    drain();
    if (spare) put_reg(REG_SPARE, 16'($urandom));
    put_reg(oac_pkg::REG_WARNING_DELAY, c.warning_delay_ticks);
    put_reg(oac_pkg::REG_ALARM_DELAY, c.alarm_delay_ticks);
    put_reg(oac_pkg::REG_DETECT_FRAMES, {8'($urandom), c.detect_frames});
    put_reg(oac_pkg::REG_CLEAR_FRAMES, {8'($urandom), c.clear_frames});
    put_reg(oac_pkg::REG_BUZZER_HALF, c.buzzer_half_period);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_wide();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return 16'd0;
    if (r < 5) return 16'hFFFF;
    return 16'($urandom_range(1, 24));
  endfunction

  function automatic logic [7:0] pick_narrow();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'd0;
    if (r < 4) return 8'd255;
    return 8'($urandom_range(1, 4));
  endfunction

  initial begin
    oac_pkg::cfg_t c;
    int unsigned   r;
    bit            busy_ep;
    logic          t;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: led stays off until something happens
    send_word(oac_pkg::KIND_TICK, 1'b0, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b1);
    send_word(oac_pkg::KIND_TICK, 1'b1, 1'b1);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);

    c = '{16'd2, 16'd3, 8'd1, 8'd1, 16'd1};
    set_config(c, 1'b1);
    send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b0);
    repeat (8) send_word(oac_pkg::KIND_TICK, 1'b0, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b1);
    send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);

    // zero thresholds and zero half period
    c = '{16'd0, 16'd0, 8'd0, 8'd0, 16'd0};
    set_config(c, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b0);
    repeat (3) send_word(oac_pkg::KIND_TICK, 1'b0, 1'b0);

    // counter saturation, raised warning delay, widest countdown
    c = '{16'd0, 16'hFFFF, 8'd255, 8'd255, 16'hFFFF};
    set_config(c, 1'b0);
    repeat (258) send_word(oac_pkg::KIND_FRAME, 1'b0, 1'b0);
    repeat (258) send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b0);
    c.warning_delay_ticks = 16'hFFFF;
    set_config(c, 1'b0);
    send_word(oac_pkg::KIND_FRAME, 1'b1, 1'b0);
    quiet = 1'b1;
    repeat (60) send_word(oac_pkg::KIND_TICK, 1'($urandom), 1'($urandom));
    quiet = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      c.warning_delay_ticks = pick_wide();
      c.alarm_delay_ticks   = pick_wide();
      c.detect_frames       = pick_narrow();
      c.clear_frames        = pick_narrow();
      c.buzzer_half_period  = pick_wide();
      set_config(c, ($urandom_range(0, 3) == 0));
      busy_ep = 1'($urandom);
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(0, 39) == 0) busy_ep = ~busy_ep;
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_word(oac_pkg::KIND_FRAME, 1'($urandom), 1'b1);
        end else if (r < 60) begin
          send_word(oac_pkg::KIND_TICK, 1'($urandom), 1'($urandom));
        end else begin
          t = busy_ep ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 19) == 0);
          send_word(oac_pkg::KIND_FRAME, t, 1'b0);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("occupancy_alarm_controller_unit verification clean");
    end else begin
      $display("occupancy_alarm_controller_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/oac_pkg.sv
sv/oac_cfg.sv
sv/oac_core.sv
sv/oac_out_fifo.sv
sv/occupancy_alarm_controller_unit.sv
verif/oac_alarm_checker.sv
verif/tb_occupancy_alarm_controller_unit.sv
